[rtl/stfp_pkg.sv]
package stfp_pkg;

  localparam int MAX_WINDOW_DEF = 63;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TEMP    = 3'd4;

  localparam logic [5:0]  WINDOW_SIZE_RST = 6'd31;
  localparam logic [15:0] LN2_Q16         = 16'd45426;

  localparam int ENTRY_DEPTH  = 4;
  localparam int RESULT_DEPTH = 2;

  typedef struct packed {
    logic [15:0]       dt;
    logic [15:0]       ds;
    logic [15:0]       lv;
    logic signed [5:0] ox;
    logic signed [5:0] oy;
    logic              rej;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic [15:0] pred;
    logic        cand;
  } result_t;

  typedef struct packed {
    logic [5:0]  window_size;
    logic [15:0] log_scale;
    logic [23:0] sigma;
  } bcfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [32:0] a;
  } ln_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [16:0] ln;
  } ln_rsp_t;

endpackage

[rtl/stfp_queue.sv]
module stfp_queue import stfp_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[rtl/stfp_front.sv]
module stfp_front import stfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [15:0]       fine_value,
  input  logic [15:0]       temporal_diff,
  input  logic [15:0]       spectral_diff,
  input  logic [15:0]       local_value,
  input  logic              sample_valid,
  input  logic signed [5:0] offset_x,
  input  logic signed [5:0] offset_y,
  input  logic [15:0]       centre_fine,
  input  logic [23:0]       similarity_tol,
  input  logic [15:0]       temporal_limit,
  input  logic [15:0]       spectral_limit,
  input  logic              last_element,
  input  logic              strict_filter,
  input  logic              use_temp_diff,
  input  logic              q_pop,
  output logic              q_empty,
  output entry_t            q_dout
);

  logic [15:0] diff;
  logic        sim_fail;
  logic        tge;
  logic        sge;
  logic        diff_fail;
  entry_t      ent;

  always_comb begin
    diff      = (centre_fine > fine_value) ? centre_fine - fine_value
                                           : fine_value - centre_fine;
    sim_fail  = {diff, 8'h00} >= similarity_tol;
    tge       = temporal_diff >= temporal_limit;
    sge       = spectral_diff >= spectral_limit;
    diff_fail = strict_filter ? (tge || sge) : (tge && sge);
    ent.dt    = use_temp_diff ? temporal_diff : 16'h0000;
    ent.ds    = spectral_diff;
    ent.lv    = local_value;
    ent.ox    = offset_x;
    ent.oy    = offset_y;
    // filter sees the temporal diff before it is zeroed
    ent.rej   = !sample_valid || sim_fail || diff_fail;
    ent.last  = last_element;
  end

  stfp_queue #(
    .W     ($bits(entry_t)),
    .DEPTH (ENTRY_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (ent),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

endmodule

[rtl/stfp_div.sv]
module stfp_div import stfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] n;
  logic [63:0] q;
  logic [47:0] d;
  logic [47:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [48:0] trial;

  assign trial = {rem, n[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      n   <= req.num;
      d   <= req.den;
      rem <= '0;
      cnt <= 6'd63;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= 48'(trial - {1'b0, d});
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= trial[47:0];
        q   <= {q[62:0], 1'b0};
      end
      n   <= {n[62:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

[rtl/stfp_ln.sv]
module stfp_ln import stfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  ln_req_t req,
  output ln_rsp_t rsp
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_NORM,
    L_MUL,
    L_UPD,
    L_SCALE
  } lstate_t;

  lstate_t     state;
  logic        done;
  logic [32:0] norm;
  logic [5:0]  p;
  logic [30:0] mm;
  logic [61:0] prod;
  logic [4:0]  lg_int;
  logic [11:0] lg_frac;
  logic [3:0]  step;
  logic [32:0] lnp;
  logic [31:0] sq;

  assign sq = prod[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            norm  <= req.a;
            p     <= 6'd32;
            state <= L_NORM;
          end
        end
        // one bit a cycle until the leading one reaches the top
        L_NORM: begin
          if (norm[32]) begin
            mm      <= norm[32:2];
            lg_int  <= 5'(p - 6'd8);
            lg_frac <= '0;
            step    <= 4'd11;
            state   <= L_MUL;
          end else begin
            norm <= {norm[31:0], 1'b0};
            p    <= p - 1'b1;
          end
        end
        L_MUL: begin
          prod  <= 62'(mm * mm);
          state <= L_UPD;
        end
        L_UPD: begin
          if (sq[31]) begin
            mm      <= sq[31:1];
            lg_frac <= {lg_frac[10:0], 1'b1};
          end else begin
            mm      <= sq[30:0];
            lg_frac <= {lg_frac[10:0], 1'b0};
          end
          if (step == 4'd0) begin
            state <= L_SCALE;
          end else begin
            step  <= step - 1'b1;
            state <= L_MUL;
          end
        end
        L_SCALE: begin
          lnp   <= 33'({lg_int, lg_frac} * LN2_Q16);
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state != L_IDLE);
  assign rsp.done = done;
  assign rsp.ln   = lnp[32:16];

endmodule

[rtl/stfp_back.sv]
module stfp_back import stfp_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  bcfg_t    cfg,
  input  logic     q_empty,
  input  entry_t   q_dout,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output ln_req_t  ln_req,
  input  ln_rsp_t  ln_rsp,
  input  logic     res_full,
  output logic     res_push,
  output result_t  res_data
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQRT,
    S_DWDIV,
    S_DWWAIT,
    S_LNT,
    S_LNT_W,
    S_LNS,
    S_LNS_W,
    S_LMUL,
    S_DMUL,
    S_PMUL,
    S_PCMP,
    S_WDIV,
    S_WWAIT,
    S_AMUL,
    S_ACC,
    S_FIN,
    S_FWAIT,
    S_OUT
  } bstate_t;

  localparam logic [15:0] PMAX = 16'((32'd1 << PIXEL_BITS) - 32'd1);

  bstate_t     state;
  entry_t      e;
  logic [47:0] wsum;
  logic [63:0] wvs;
  logic        cand;
  logic [15:0] first_c;
  logic [15:0] last_c;
  logic        centre_seen;
  logic [27:0] sq_rem;
  logic [27:0] sq_res;
  logic [27:0] sq_bit;
  logic [12:0] dw;
  logic [16:0] lt;
  logic [16:0] lsn;
  logic [33:0] p1;
  logic [33:0] dts;
  logic [47:0] den;
  logic [31:0] w;
  logic [47:0] wl;
  logic [15:0] pred;

  logic [5:0]  ax;
  logic [5:0]  ay;
  logic [11:0] d2;
  logic [27:0] sq_t;
  logic [7:0]  ws8;
  logic [7:0]  ws_eff;
  logic        use_log;
  logic        use_div_fin;
  logic [48:0] ws_add;
  logic [64:0] wv_add;
  logic [16:0] cmean;
  logic        is_centre;

  always_comb begin
    ax        = q_dout.ox[5] ? 6'(~q_dout.ox + 6'sd1) : q_dout.ox;
    ay        = q_dout.oy[5] ? 6'(~q_dout.oy + 6'sd1) : q_dout.oy;
    d2        = 12'(ax * ax) + 12'(ay * ay);
    is_centre = (q_dout.ox == 6'sd0) && (q_dout.oy == 6'sd0);
    sq_t      = sq_res + sq_bit;
    ws8       = {2'b00, cfg.window_size};
    if (ws8 < 8'd3) begin
      ws_eff = 8'd3;
    end else if (ws8 > 8'(MAX_WINDOW)) begin
      ws_eff = 8'(MAX_WINDOW);
    end else begin
      ws_eff = ws8;
    end
    use_log     = (cfg.log_scale != 16'h0000);
    use_div_fin = cand && (wsum != '0);
    ws_add      = {1'b0, wsum} + 49'(w);
    wv_add      = {1'b0, wvs} + 65'(wl);
    cmean       = 17'(first_c) + 17'(last_c);
  end

  always_comb begin
    q_pop         = (state == S_IDLE) && !q_empty;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    ln_req.start  = 1'b0;
    ln_req.a      = '0;
    unique case (state)
      S_DWDIV: begin
        div_req.start = 1'b1;
        div_req.num   = 64'({sq_res[13:0], 1'b0});
        div_req.den   = 48'(ws_eff);
      end
      S_WDIV: begin
        div_req.start = 1'b1;
        div_req.num   = use_log ? (64'd1 << 56) : (64'd1 << 32);
        div_req.den   = den;
      end
      S_FIN: begin
        div_req.start = use_div_fin;
        div_req.num   = wvs;
        div_req.den   = wsum;
      end
      S_LNT: begin
        ln_req.start = 1'b1;
        ln_req.a     = 33'd512 + 33'(e.dt * cfg.log_scale);
      end
      S_LNS: begin
        ln_req.start = 1'b1;
        ln_req.a     = 33'd512 + 33'(e.ds * cfg.log_scale);
      end
      default: begin
      end
    endcase
    res_push      = (state == S_OUT) && !res_full;
    res_data.pred = pred;
    res_data.cand = cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wsum        <= '0;
      wvs         <= '0;
      cand        <= 1'b0;
      first_c     <= '0;
      last_c      <= '0;
      centre_seen <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            e      <= q_dout;
            sq_rem <= {d2, 16'h0000};
            sq_res <= '0;
            sq_bit <= 28'd1 << 26;
            if (is_centre) begin
              if (!centre_seen) begin
                first_c <= q_dout.lv;
              end
              last_c      <= q_dout.lv;
              centre_seen <= 1'b1;
            end
            if (!q_dout.rej) begin
              state <= S_SQRT;
            end else if (q_dout.last) begin
              state <= S_FIN;
            end
          end
        end
        // integer square root, found digit by digit
        S_SQRT: begin
          if (sq_rem >= sq_t) begin
            sq_rem <= sq_rem - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= S_DWDIV;
          end
        end
        S_DWDIV: state <= S_DWWAIT;
        S_DWWAIT: begin
          if (div_rsp.done) begin
            dw    <= 13'd256 + div_rsp.quot[12:0];
            state <= use_log ? S_LNT : S_PMUL;
          end
        end
        S_LNT: state <= S_LNT_W;
        S_LNT_W: begin
          if (ln_rsp.done) begin
            lt    <= ln_rsp.ln;
            state <= S_LNS;
          end
        end
        S_LNS: state <= S_LNS_W;
        S_LNS_W: begin
          if (ln_rsp.done) begin
            lsn   <= ln_rsp.ln;
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          p1    <= 34'(lt * lsn);
          state <= S_DMUL;
        end
        S_DMUL: begin
          den   <= 48'(p1 * dw);
          state <= S_WDIV;
        end
        S_PMUL: begin
          dts   <= 34'((17'(e.dt) + 17'd1) * (17'(e.ds) + 17'd1));
          state <= S_PCMP;
        end
        S_PCMP: begin
          den <= 48'(dts * dw);
          if ({dts, 8'h00} >= 42'(cfg.sigma)) begin
            state <= S_WDIV;
          end else begin
            w     <= 32'd1 << 24;
            state <= S_AMUL;
          end
        end
        S_WDIV: state <= S_WWAIT;
        S_WWAIT: begin
          if (div_rsp.done) begin
            w     <= div_rsp.quot[31:0];
            state <= S_AMUL;
          end
        end
        S_AMUL: begin
          wl    <= 48'(w * e.lv);
          state <= S_ACC;
        end
        S_ACC: begin
          wsum  <= ws_add[48] ? '1 : ws_add[47:0];
          wvs   <= wv_add[64] ? '1 : wv_add[63:0];
          cand  <= 1'b1;
          state <= e.last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (use_div_fin) begin
            state <= S_FWAIT;
          end else begin
            pred  <= (cmean[16:1] > PMAX) ? PMAX : cmean[16:1];
            state <= S_OUT;
          end
        end
        S_FWAIT: begin
          if (div_rsp.done) begin
            pred  <= (div_rsp.quot > 64'(PMAX)) ? PMAX : div_rsp.quot[15:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full) begin
            wsum        <= '0;
            wvs         <= '0;
            cand        <= 1'b0;
            first_c     <= '0;
            last_c      <= '0;
            centre_seen <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/spatiotemporal_fusion_pixel.sv]
// A rejected element leaves the back end with no further steps; a counted element's time is
// set by the 64-step serial divider (run twice, or once for a plain weight that falls under
// sigma) and, for the log weight, the ln unit run twice; a last element adds the final divide
// (when the weight sum is nonzero) and hand-off to the result queue.
// The back end takes the next element only after it returns to idle; a 4-word queue decouples input.
// Reset: registers to defaults (window 31, temporal diff on), queues empty, sums cleared.
module spatiotemporal_fusion_pixel import stfp_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [15:0]           fine_value,
  input  logic [15:0]           temporal_diff,
  input  logic [15:0]           spectral_diff,
  input  logic [15:0]           local_value,
  input  logic                  sample_valid,
  input  logic signed [5:0]     offset_x,
  input  logic signed [5:0]     offset_y,
  input  logic [15:0]           centre_fine,
  input  logic [23:0]           similarity_tol,
  input  logic [15:0]           temporal_limit,
  input  logic [15:0]           spectral_limit,
  input  logic                  last_element,
  output logic                  empty,
  input  logic                  pop,
  output logic [15:0]           predicted_value,
  output logic                  had_candidate,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [5:0]  window_size;
  logic [15:0] log_scale;
  logic [23:0] sigma_thr;
  logic        strict_filter;
  logic        use_temp_diff;

  bcfg_t    bcfg;
  logic     q_pop;
  logic     q_empty;
  entry_t   q_dout;
  div_req_t div_req;
  div_rsp_t div_rsp;
  ln_req_t  ln_req;
  ln_rsp_t  ln_rsp;
  logic     res_full;
  logic     res_push;
  result_t  res_data;
  result_t  res_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WINDOW_SIZE_RST;
      log_scale      <= '0;
      sigma_thr      <= '0;
      strict_filter  <= 1'b0;
      use_temp_diff  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: window_size    <= cfg_data[5:0];
        CFG_LOG_SCALE:   log_scale      <= cfg_data[15:0];
        CFG_SIGMA:       sigma_thr      <= cfg_data[23:0];
        CFG_STRICT:      strict_filter  <= cfg_data[0];
        CFG_USE_TEMP:    use_temp_diff  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign bcfg.window_size = window_size;
  assign bcfg.log_scale   = log_scale;
  assign bcfg.sigma       = sigma_thr;

  stfp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .fine_value     (fine_value),
    .temporal_diff  (temporal_diff),
    .spectral_diff  (spectral_diff),
    .local_value    (local_value),
    .sample_valid   (sample_valid),
    .offset_x       (offset_x),
    .offset_y       (offset_y),
    .centre_fine    (centre_fine),
    .similarity_tol (similarity_tol),
    .temporal_limit (temporal_limit),
    .spectral_limit (spectral_limit),
    .last_element   (last_element),
    .strict_filter  (strict_filter),
    .use_temp_diff  (use_temp_diff),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_dout         (q_dout)
  );

  stfp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  stfp_ln u_ln (
    .clk (clk),
    .rst (rst),
    .req (ln_req),
    .rsp (ln_rsp)
  );

  stfp_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (bcfg),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .ln_req   (ln_req),
    .ln_rsp   (ln_rsp),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  stfp_queue #(
    .W     ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_data),
    .pop   (pop),
    .empty (empty),
    .dout  (res_dout)
  );

  assign predicted_value = res_dout.pred;
  assign had_candidate   = res_dout.cand;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result word pushed into full queue");

  a_entry_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("entry word popped from empty queue");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_ln_idle_start: assert property (@(posedge clk) disable iff (rst)
    ln_req.start |-> !ln_rsp.busy)
    else $error("ln unit restarted while busy");

endmodule
